/* rtl/sate_pkg.sv */
// Shared types, widths and codes of the sorted array table engine.
package sate_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 4;
    localparam int CMD_W        = 3;
    localparam int STAT_W       = 2;
    localparam int CNT_OUT_W    = 5;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_cmd CMD_INSERT    = 3'd0;
    localparam t_cmd CMD_DELETE    = 3'd1;
    localparam t_cmd CMD_READ      = 3'd2;
    localparam t_cmd CMD_CHECK     = 3'd3;
    localparam t_cmd CMD_PARTITION = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

endpackage

/* rtl/sate_ram.sv */
// Entry store: one write port and one registered read port.
module sate_ram
    import sate_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sate_cmp.sv */
// Shared signed greater-than comparator used by the insert, check and partition walks of the sequencer.
module sate_cmp
    import sate_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic                     o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

/* rtl/sorted_array_table_engine.sv */
// Sorted array table engine: sequencer, handshake and result register.
// One command is taken when o_ready is high and runs alone. Its result is loaded after the
// walk through the single read port of the store: insert walks the entries above the new
// value, delete the entries after the index, read fetches one entry and partition scans from
// both ends with a swap per pair. A full insert or an index out of range adds no walk. A
// sortedness pass follows a partition of two or more entries, and also an insert or delete
// when the array was not sorted. The next command can be accepted in the cycle after its
// result is loaded, while that result still waits on the output. A result that still waits
// holds the next result, and so the input, back.
module sorted_array_table_engine
    import sate_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic [IDX_W-1:0]         i_index,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [CNT_OUT_W-1:0]     o_count,
    output logic                     o_is_sorted
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + IDX_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_INS      = 4'd2;
    localparam logic [3:0] S_INS_LAST = 4'd3;
    localparam logic [3:0] S_DEL      = 4'd4;
    localparam logic [3:0] S_RD       = 4'd5;
    localparam logic [3:0] S_PL       = 4'd6;
    localparam logic [3:0] S_PH       = 4'd7;
    localparam logic [3:0] S_PSW      = 4'd8;
    localparam logic [3:0] S_PSW2     = 4'd9;
    localparam logic [3:0] S_POST     = 4'd10;
    localparam logic [3:0] S_CHK      = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    localparam logic signed [CW:0] ONE_S  = 1;
    localparam logic signed [CW:0] ZERO_S = 0;
    localparam logic signed [CW:0] MONE_S = -1;

    localparam logic signed [DATA_W-1:0] MONE_W = -1;

    logic [3:0]               r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_sorted, n_sorted;
    logic                     r_need, n_need;
    logic [AW-1:0]            r_ptr, n_ptr;
    logic signed [CW:0]       r_lo, n_lo;
    logic signed [CW:0]       r_hi, n_hi;
    logic signed [DATA_W-1:0] r_lov, n_lov;
    logic signed [DATA_W-1:0] r_hiv, n_hiv;
    logic signed [DATA_W-1:0] r_prev, n_prev;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_rd, n_rd;
    logic                     r_ovalid, n_ovalid;
    t_status                  r_o_status, n_o_status;
    logic signed [DATA_W-1:0] r_o_rd, n_o_rd;
    logic [CNT_OUT_W-1:0]     r_o_count, n_o_count;
    logic                     r_o_sorted, n_o_sorted;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata_u;
    logic signed [DATA_W-1:0] ram_rdata;

    logic signed [DATA_W-1:0] cmp_a, cmp_b;
    logic                     cmp_gt;

    logic [XW-1:0]            idx_x, cnt_x, idx1_x;
    logic [CW-1:0]            cnt_m1;
    logic signed [CW:0]       n_s, lo_inc, hi_dec;

    assign ram_rdata = ram_rdata_u;
    assign idx_x     = {{CW{1'b0}}, r_idx};
    assign cnt_x     = {{IDX_W{1'b0}}, r_count};
    assign idx1_x    = idx_x + XW'(1);
    assign cnt_m1    = r_count - CW'(1);
    assign n_s       = signed'({1'b0, r_count});
    assign lo_inc    = r_lo + ONE_S;
    assign hi_dec    = r_hi - ONE_S;

    sate_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_u)
    );

    sate_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    // insert: entry > value; check: previous > current; partition: entry >= 0
    always_comb begin
        case (r_state)
            S_INS: begin
                cmp_a = ram_rdata;
                cmp_b = r_value;
            end
            S_CHK: begin
                cmp_a = r_prev;
                cmp_b = ram_rdata;
            end
            default: begin
                cmp_a = ram_rdata;
                cmp_b = MONE_W;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_idx      = r_idx;
        n_count    = r_count;
        n_sorted   = r_sorted;
        n_need     = r_need;
        n_ptr      = r_ptr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_lov      = r_lov;
        n_hiv      = r_hiv;
        n_prev     = r_prev;
        n_status   = r_status;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid & ~i_ready;
        n_o_status = r_o_status;
        n_o_rd     = r_o_rd;
        n_o_count  = r_o_count;
        n_o_sorted = r_o_sorted;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_value;
        ram_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_value  = i_value;
                    n_idx    = i_index;
                    n_status = ST_DONE;
                    n_rd     = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_need  = 1'b0;
                n_state = S_POST;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            ram_we  = 1'b1;
                            n_count = r_count + CW'(1);
                            n_need  = ~r_sorted;
                        end else begin
                            ram_raddr = cnt_m1[AW-1:0];
                            n_ptr     = cnt_m1[AW-1:0];
                            n_state   = S_INS;
                        end
                    end
                    CMD_DELETE: begin
                        if (!(idx_x < cnt_x)) begin
                            n_status = ST_RANGE;
                        end else if (idx1_x == cnt_x) begin
                            n_count = cnt_m1;
                            n_need  = ~r_sorted;
                        end else begin
                            ram_raddr = idx1_x[AW-1:0];
                            n_ptr     = idx1_x[AW-1:0];
                            n_state   = S_DEL;
                        end
                    end
                    CMD_READ: begin
                        if (idx_x < cnt_x) begin
                            ram_raddr = idx_x[AW-1:0];
                            n_state   = S_RD;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    CMD_PARTITION: begin
                        n_need = 1'b1;
                        n_lo   = ZERO_S;
                        n_hi   = n_s - ONE_S;
                        if ((n_s - ONE_S) > ZERO_S) begin
                            n_state = S_PL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr + AW'(1);
                if (cmp_gt) begin
                    ram_wdata = ram_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_INS_LAST;
                    end else begin
                        ram_raddr = r_ptr - AW'(1);
                        n_ptr     = r_ptr - AW'(1);
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_need  = ~r_sorted;
                    n_state = S_POST;
                end
            end
            S_INS_LAST: begin
                ram_we  = 1'b1;
                n_count = r_count + CW'(1);
                n_need  = ~r_sorted;
                n_state = S_POST;
            end
            S_DEL: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr - AW'(1);
                ram_wdata = ram_rdata;
                if (CW'(r_ptr) == cnt_m1) begin
                    n_count = cnt_m1;
                    n_need  = ~r_sorted;
                    n_state = S_POST;
                end else begin
                    ram_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end
            S_RD: begin
                n_rd    = ram_rdata;
                n_state = S_POST;
            end
            S_PL: begin
                if (!cmp_gt && (lo_inc < n_s)) begin
                    n_lo      = lo_inc;
                    ram_raddr = lo_inc[AW-1:0];
                end else begin
                    if (!cmp_gt) begin
                        n_lo = lo_inc;
                    end else begin
                        n_lov = ram_rdata;
                    end
                    if (r_hi >= ZERO_S) begin
                        ram_raddr = r_hi[AW-1:0];
                        n_state   = S_PH;
                    end else begin
                        n_state = S_PSW;
                    end
                end
            end
            S_PH: begin
                if (cmp_gt) begin
                    n_hi = hi_dec;
                    if (hi_dec >= ZERO_S) begin
                        ram_raddr = hi_dec[AW-1:0];
                    end else begin
                        n_state = S_PSW;
                    end
                end else begin
                    n_hiv   = ram_rdata;
                    n_state = S_PSW;
                end
            end
            S_PSW: begin
                if (r_lo < r_hi) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                    ram_wdata = r_hiv;
                    n_state   = S_PSW2;
                end else begin
                    n_state = S_POST;
                end
            end
            S_PSW2: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi[AW-1:0];
                ram_wdata = r_lov;
                ram_raddr = r_lo[AW-1:0];
                n_state   = S_PL;
            end
            S_POST: begin
                if (!r_need) begin
                    n_state = S_DONE;
                end else if (r_count <= CW'(1)) begin
                    n_sorted = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_ptr   = '0;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_prev = ram_rdata;
                if ((r_ptr != '0) && cmp_gt) begin
                    n_sorted = 1'b0;
                    n_state  = S_DONE;
                end else if (CW'(r_ptr) == cnt_m1) begin
                    n_sorted = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    ram_raddr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_rd     = r_rd;
                    n_o_count  = cnt_x[CNT_OUT_W-1:0];
                    n_o_sorted = r_sorted;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sorted <= 1'b1;
            r_need   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sorted <= n_sorted;
            r_need   <= n_need;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_lov      <= n_lov;
        r_hiv      <= n_hiv;
        r_prev     <= n_prev;
        r_status   <= n_status;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_rd     <= n_o_rd;
        r_o_count  <= n_o_count;
        r_o_sorted <= n_o_sorted;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_o_status;
    assign o_read_value = r_o_rd;
    assign o_count      = r_o_count;
    assign o_is_sorted  = r_o_sorted;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + CW'(1)) || (r_count == $past(r_count) - CW'(1))))
        else $error("entry count moved by more than one");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PL) || (r_state == S_PH) || (r_state == S_PSW) || (r_state == S_PSW2))
            |-> ((r_lo <= n_s) && (r_hi >= MONE_S) && (r_lo >= ZERO_S)))
        else $error("partition pointer out of range");

    a_small_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_count <= CW'(1))) |-> r_sorted)
        else $error("short array not flagged sorted");

endmodule
